// ===== hw/rtl/nnds_pkg.sv =====
// Package for the nearest-neighbour RGB downscaler.
// Holds pixel payload types, register indexes, queue constants and the size clamp.
// No dependencies.
package nnds_pkg;

  localparam int REG_W   = 13;
  localparam int CNT_W   = 12;
  localparam int REM_W   = 14;
  localparam int CHAN_W  = 8;
  localparam int IDX_W   = 2;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
  localparam logic [IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

  localparam logic [REG_W-1:0] RESET_SOURCE_WIDTH  = 13'd640;
  localparam logic [REG_W-1:0] RESET_SOURCE_HEIGHT = 13'd480;
  localparam logic [REG_W-1:0] RESET_TARGET_WIDTH  = 13'd96;
  localparam logic [REG_W-1:0] RESET_TARGET_HEIGHT = 13'd96;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } in_pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_end;
  } out_pixel_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [REG_W-1:0] clamp_size(input logic [REG_W-1:0] v,
                                                  input logic [REG_W-1:0] lim);
    logic [REG_W-1:0] r;
    if (v == '0) begin
      r = {{(REG_W-1){1'b0}}, 1'b1};
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [REM_W-1:0] advance_rem(input logic [REM_W-1:0] rem,
                                                   input logic [REG_W-1:0] src,
                                                   input logic [REG_W-1:0] tgt);
    logic [REM_W:0]   sum;
    logic [REM_W-1:0] r;
    sum = {1'b0, rem} + {2'b00, src} - {2'b00, tgt};
    if (rem >= {1'b0, tgt}) begin
      r = rem - {1'b0, tgt};
    end else begin
      r = sum[REM_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/nnds_front.sv =====
// Front stage: size registers, source/output counters and remainder tracking.
// Classifies each accepted pixel and pushes selected ones into the queue.
// Depends on nnds_pkg.
module nnds_front #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [nnds_pkg::IDX_W-1:0] cfg_index,
  input  logic [nnds_pkg::REG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  nnds_pkg::in_pixel_t       in_data,
  input  nnds_pkg::q_stat_t         q_stat,
  output logic                      push,
  output nnds_pkg::out_pixel_t      push_data
);

  localparam logic [nnds_pkg::REG_W-1:0] DIM_LIM =
    (MAX_DIMENSION > 8191) ? 13'd8191 : nnds_pkg::REG_W'(MAX_DIMENSION);

  logic [nnds_pkg::REG_W-1:0] src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic [nnds_pkg::CNT_W-1:0] src_col_r, src_col_nxt, src_row_r, src_row_nxt;
  logic [nnds_pkg::CNT_W-1:0] out_col_r, out_col_nxt, out_row_r, out_row_nxt;
  logic [nnds_pkg::REM_W-1:0] col_rem_r, col_rem_nxt, row_rem_r, row_rem_nxt;

  logic [nnds_pkg::REG_W-1:0] w, h, tw, th;
  logic                       row_taken, col_taken, accept, last_col, last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= nnds_pkg::RESET_SOURCE_WIDTH;
      src_h_r <= nnds_pkg::RESET_SOURCE_HEIGHT;
      tgt_w_r <= nnds_pkg::RESET_TARGET_WIDTH;
      tgt_h_r <= nnds_pkg::RESET_TARGET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nnds_pkg::REG_SOURCE_WIDTH:  src_w_r <= cfg_data;
        nnds_pkg::REG_SOURCE_HEIGHT: src_h_r <= cfg_data;
        nnds_pkg::REG_TARGET_WIDTH:  tgt_w_r <= cfg_data;
        nnds_pkg::REG_TARGET_HEIGHT: tgt_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w  = nnds_pkg::clamp_size(src_w_r, DIM_LIM);
  assign h  = nnds_pkg::clamp_size(src_h_r, DIM_LIM);
  assign tw = nnds_pkg::clamp_size(tgt_w_r, w);
  assign th = nnds_pkg::clamp_size(tgt_h_r, h);

  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign row_taken = row_rem_r < {1'b0, th};
  assign col_taken = col_rem_r < {1'b0, tw};
  assign last_col  = {1'b0, src_col_r} >= (w - 13'd1);
  assign last_row  = {1'b0, src_row_r} >= (h - 13'd1);

  assign push                = accept && row_taken && col_taken;
  assign push_data.red_out   = in_data.red_in;
  assign push_data.green_out = in_data.green_in;
  assign push_data.blue_out  = in_data.blue_in;
  assign push_data.frame_end = ({1'b0, out_row_r} == (th - 13'd1)) &&
                               ({1'b0, out_col_r} == (tw - 13'd1));

  always_comb begin
    src_col_nxt = src_col_r;
    src_row_nxt = src_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    col_rem_nxt = col_rem_r;
    row_rem_nxt = row_rem_r;
    if (accept) begin
      if (row_taken && col_taken) begin
        out_col_nxt = out_col_r + 12'd1;
      end
      if (last_col) begin
        src_col_nxt = '0;
        col_rem_nxt = '0;
        out_col_nxt = '0;
        if (row_taken) begin
          out_row_nxt = out_row_r + 12'd1;
        end
        if (last_row) begin
          src_row_nxt = '0;
          row_rem_nxt = '0;
          out_row_nxt = '0;
        end else begin
          src_row_nxt = src_row_r + 12'd1;
          row_rem_nxt = nnds_pkg::advance_rem(row_rem_r, h, th);
        end
      end else begin
        src_col_nxt = src_col_r + 12'd1;
        col_rem_nxt = nnds_pkg::advance_rem(col_rem_r, w, tw);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      src_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      col_rem_r <= '0;
      row_rem_r <= '0;
    end else begin
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      col_rem_r <= col_rem_nxt;
      row_rem_r <= row_rem_nxt;
    end
  end

endmodule

// ===== hw/rtl/nnds_queue.sv =====
// Short queue between front and back stages of the downscaler.
// Holds selected pixels; reports full and empty as one status struct.
// Depends on nnds_pkg.
module nnds_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  nnds_pkg::out_pixel_t push_data,
  input  logic                 pop,
  output nnds_pkg::out_pixel_t pop_data,
  output nnds_pkg::q_stat_t    q_stat
);

  nnds_pkg::out_pixel_t               mem_r [nnds_pkg::Q_DEPTH];
  logic [nnds_pkg::Q_PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [nnds_pkg::Q_CNT_W-1:0]       count_r, count_nxt;

  assign q_stat.full  = count_r == nnds_pkg::Q_CNT_W'(nnds_pkg::Q_DEPTH);
  assign q_stat.empty = count_r == '0;
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 3'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 2'd1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/nnds_back.sv =====
// Back stage: output register of the downscaler result channel.
// Pulls from the queue whenever the register is free or being drained.
// Depends on nnds_pkg.
module nnds_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nnds_pkg::q_stat_t    q_stat,
  input  nnds_pkg::out_pixel_t pop_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output nnds_pkg::out_pixel_t out_data
);

  logic                 out_valid_r, out_valid_nxt;
  nnds_pkg::out_pixel_t out_data_r;

  assign pop           = !q_stat.empty && (!out_valid_r || !out_stall);
  assign out_valid_nxt = pop || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= pop_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/nearest_neighbor_rgb_downscaler_core.sv =====
// Nearest-neighbour RGB888 downscaler, top level.
// Takes one source pixel per clock in raster order while in_stall is low and passes on the
// pixels that land on the target grid; frame_end marks the last pixel of each output frame.
// Sizes are written through the cfg_ port (index 0..3: source width, source height, target
// width, target height) and are clamped so that only downscaling happens. In the front
// counter stage the column remainder updates per accepted pixel, the row remainder per source
// row; a selected pixel then passes a four-entry queue and the output register. Input is
// stalled only when the queue is full. Depends on nnds_pkg, nnds_front, nnds_queue, nnds_back.
module nearest_neighbor_rgb_downscaler_core #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [nnds_pkg::IDX_W-1:0] cfg_index,
  input  logic [nnds_pkg::REG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  nnds_pkg::in_pixel_t        in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output nnds_pkg::out_pixel_t       out_data
);

  logic                 push, pop;
  nnds_pkg::out_pixel_t push_data, pop_data;
  nnds_pkg::q_stat_t    q_stat;

  assign cfg_ready = 1'b1;

  nnds_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data)
  );

  nnds_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .q_stat   (q_stat)
  );

  nnds_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ===== hw/rtl/nnds_checker.sv =====
// Port-level checks for the downscaler top level, attached by bind.
// Watches the result channel and input back-pressure. Depends on nnds_pkg.
module nnds_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input nnds_pkg::out_pixel_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("queue filled without output back-pressure");

endmodule

bind nearest_neighbor_rgb_downscaler_core nnds_checker u_nnds_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
